@@ rtl/stcg_pkg.sv @@
// Shared widths, payload types and the arctangent table of the spherical texture coordinate generator.
package stcg_pkg;

  // Coordinate format and internal widths.
  localparam int COORD_W  = 16;
  localparam int GUARD_W  = 46 - COORD_W;
  localparam int CORDIC_W = COORD_W + GUARD_W + 3;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int TURN_W   = 32;
  localparam int ANG_W    = TURN_W + 2;
  localparam int TEX_W    = 16;

  // Pipeline shape.
  localparam int FRONT_STAGES      = 3;
  localparam int SQRT_STAGES       = COORD_W;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int LANES             = 2;
  localparam int LANE_U            = 0;
  localparam int LANE_V            = 1;

  // Fixed result codes for the special cases.
  localparam logic [TEX_W-1:0] U_ZERO         = 16'h0000;
  localparam logic [TEX_W-1:0] U_QUARTER_POS  = 16'h4000;
  localparam logic [TEX_W-1:0] U_HALF         = 16'h8000;
  localparam logic [TEX_W-1:0] U_QUARTER_NEG  = 16'hC000;
  localparam logic [TEX_W-1:0] V_ZERO         = 16'h0000;
  localparam logic [TEX_W-1:0] V_HALF         = 16'h8000;
  localparam logic [TEX_W-1:0] V_MAX          = 16'hFFFF;

  typedef logic signed [CORDIC_W-1:0] cval_t;
  typedef logic signed [ANG_W-1:0]    ang_t;

  localparam ang_t HALF_TURN = ang_t'(64'd2147483648);

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } pos_t;

  typedef struct packed {
    logic signed [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic                    zero_vector;
  } tex_t;

  typedef struct packed {
    logic zero_vector;
    logic x_zero;
    logic x_neg;
    logic z_zero;
    logic z_pos;
    logic y_zero;
    logic y_pos;
    logic xz_zero;
  } flags_t;

  typedef struct packed {
    pos_t   pos;
    flags_t flags;
  } sq_side_t;

  // Arctangent of 2^-idx in binary angle units, 2^32 to the turn.
  function automatic ang_t atan_unit(input int unsigned idx);
    logic [TURN_W-1:0] val;
    case (idx)
      0:       val = 32'h2000_0000;
      1:       val = 32'h12E4_051D;
      2:       val = 32'h09FB_385B;
      3:       val = 32'h0511_11D4;
      4:       val = 32'h028B_0D43;
      5:       val = 32'h0145_D7E1;
      6:       val = 32'h00A2_F61E;
      7:       val = 32'h0051_7C55;
      8:       val = 32'h0028_BE53;
      9:       val = 32'h0014_5F2E;
      10:      val = 32'h000A_2F98;
      11:      val = 32'h0005_17CC;
      12:      val = 32'h0002_8BE6;
      13:      val = 32'h0001_45F3;
      14:      val = 32'h0000_A2F9;
      15:      val = 32'h0000_517C;
      16:      val = 32'h0000_28BE;
      17:      val = 32'h0000_145F;
      18:      val = 32'h0000_0A2F;
      19:      val = 32'h0000_0517;
      20:      val = 32'h0000_028B;
      21:      val = 32'h0000_0145;
      22:      val = 32'h0000_00A2;
      23:      val = 32'h0000_0051;
      24:      val = 32'h0000_0028;
      25:      val = 32'h0000_0014;
      26:      val = 32'h0000_000A;
      27:      val = 32'h0000_0005;
      28:      val = 32'h0000_0002;
      29:      val = 32'h0000_0001;
      default: val = '0;
    endcase
    return ang_t'(val);
  endfunction

endpackage

@@ rtl/stcg_front.sv @@
// Front end: input register, axis flags, squares of x and z and their sum.
module stcg_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  stcg_pkg::pos_t                pos_i,
  output logic                          valid_o,
  output stcg_pkg::sq_side_t            side_o,
  output logic [stcg_pkg::SQ_W-1:0]     sum_o
);

  localparam int CW = stcg_pkg::COORD_W;
  localparam int SW = stcg_pkg::SQ_W;

  logic               s1_valid_q, s2_valid_q, s3_valid_q;
  stcg_pkg::pos_t     s1_pos_q;
  stcg_pkg::sq_side_t s2_side_q, s3_side_q;
  logic [SW-1:0]      s2_sqx_q, s2_sqz_q, s3_sum_q;

  logic [CW-1:0]      mag_x, mag_z;
  stcg_pkg::flags_t   flags_d;

  always_comb begin
    mag_x = s1_pos_q.pos_x[CW-1] ? CW'(-s1_pos_q.pos_x) : CW'(s1_pos_q.pos_x);
    mag_z = s1_pos_q.pos_z[CW-1] ? CW'(-s1_pos_q.pos_z) : CW'(s1_pos_q.pos_z);
    flags_d.x_zero      = (s1_pos_q.pos_x == '0);
    flags_d.y_zero      = (s1_pos_q.pos_y == '0);
    flags_d.z_zero      = (s1_pos_q.pos_z == '0);
    flags_d.x_neg       = s1_pos_q.pos_x[CW-1];
    flags_d.z_pos       = !flags_d.z_zero && !s1_pos_q.pos_z[CW-1];
    flags_d.y_pos       = !flags_d.y_zero && !s1_pos_q.pos_y[CW-1];
    flags_d.xz_zero     = flags_d.x_zero && flags_d.z_zero;
    flags_d.zero_vector = flags_d.xz_zero && flags_d.y_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pos_q        <= pos_i;
    s2_side_q.pos   <= s1_pos_q;
    s2_side_q.flags <= flags_d;
    s2_sqx_q        <= SW'(mag_x) * SW'(mag_x);
    s2_sqz_q        <= SW'(mag_z) * SW'(mag_z);
    s3_side_q       <= s2_side_q;
    s3_sum_q        <= s2_sqx_q + s2_sqz_q;
  end

  assign valid_o = s3_valid_q;
  assign side_o  = s3_side_q;
  assign sum_o   = s3_sum_q;

endmodule

@@ rtl/stcg_isqrt.sv @@
// Pipelined integer floor square root, one result bit per stage.
module stcg_isqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  stcg_pkg::sq_side_t              side_i,
  input  logic [stcg_pkg::SQ_W-1:0]       rad_i,
  output logic                            valid_o,
  output stcg_pkg::sq_side_t              side_o,
  output logic [stcg_pkg::COORD_W-1:0]    root_o
);

  localparam int SW    = stcg_pkg::SQ_W;
  localparam int RES_W = SW + 1;
  localparam int N     = stcg_pkg::SQRT_STAGES;

  logic               valid_q [N];
  stcg_pkg::sq_side_t side_q  [N];
  logic [SW-1:0]      rem_q   [N];
  logic [RES_W-1:0]   res_q   [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [RES_W-1:0] BIT = RES_W'(1) << (SW - 2 - 2 * k);

    logic               in_valid;
    stcg_pkg::sq_side_t in_side;
    logic [SW-1:0]      in_rem;
    logic [RES_W-1:0]   in_res;
    logic [RES_W-1:0]   trial;
    logic [SW-1:0]      rem_d;
    logic [RES_W-1:0]   res_d;

    if (k == 0) begin : g_first
      assign in_valid = valid_i;
      assign in_side  = side_i;
      assign in_rem   = rad_i;
      assign in_res   = '0;
    end else begin : g_next
      assign in_valid = valid_q[k-1];
      assign in_side  = side_q[k-1];
      assign in_rem   = rem_q[k-1];
      assign in_res   = res_q[k-1];
    end

    always_comb begin
      trial = in_res + BIT;
      if (RES_W'(in_rem) >= trial) begin
        rem_d = SW'(RES_W'(in_rem) - trial);
        res_d = (in_res >> 1) + BIT;
      end else begin
        rem_d = in_rem;
        res_d = in_res >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= in_side;
      rem_q[k]  <= rem_d;
      res_q[k]  <= res_d;
    end
  end

  assign valid_o = valid_q[N-1];
  assign side_o  = side_q[N-1];
  assign root_o  = res_q[N-1][stcg_pkg::COORD_W-1:0];

endmodule

@@ rtl/stcg_cordic.sv @@
// Two-lane pipelined vectoring CORDIC giving the binary angle of each input vector.
module stcg_cordic #(
  parameter int STAGES = stcg_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  stcg_pkg::flags_t  flags_i,
  input  stcg_pkg::cval_t   vec_x_i [stcg_pkg::LANES],
  input  stcg_pkg::cval_t   vec_y_i [stcg_pkg::LANES],
  output logic              valid_o,
  output stcg_pkg::flags_t  flags_o,
  output stcg_pkg::ang_t    ang_o   [stcg_pkg::LANES]
);

  localparam int L  = stcg_pkg::LANES;
  localparam int CW = stcg_pkg::CORDIC_W;

  logic             valid_q [STAGES+1];
  stcg_pkg::flags_t flags_q [STAGES+1];
  stcg_pkg::cval_t  x_q     [STAGES+1][L];
  stcg_pkg::cval_t  y_q     [STAGES+1][L];
  stcg_pkg::ang_t   ang_q   [STAGES+1][L];

  for (genvar k = 0; k <= STAGES; k++) begin : g_stage
    stcg_pkg::cval_t x_d   [L];
    stcg_pkg::cval_t y_d   [L];
    stcg_pkg::ang_t  ang_d [L];

    if (k == 0) begin : g_pre
      // Vectors in the left half-plane are turned by half a turn first.
      always_comb begin
        for (int l = 0; l < L; l++) begin
          if (vec_x_i[l][CW-1]) begin
            x_d[l]   = -vec_x_i[l];
            y_d[l]   = -vec_y_i[l];
            ang_d[l] = vec_y_i[l][CW-1] ? -stcg_pkg::HALF_TURN : stcg_pkg::HALF_TURN;
          end else begin
            x_d[l]   = vec_x_i[l];
            y_d[l]   = vec_y_i[l];
            ang_d[l] = '0;
          end
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[k] <= 1'b0;
        end else begin
          valid_q[k] <= valid_i;
        end
      end

      always_ff @(posedge clk_i) begin
        flags_q[k] <= flags_i;
      end
    end else begin : g_iter
      localparam int SHIFT = k - 1;

      always_comb begin
        for (int l = 0; l < L; l++) begin
          if (!y_q[k-1][l][CW-1]) begin
            x_d[l]   = x_q[k-1][l] + (y_q[k-1][l] >>> SHIFT);
            y_d[l]   = y_q[k-1][l] - (x_q[k-1][l] >>> SHIFT);
            ang_d[l] = ang_q[k-1][l] + stcg_pkg::atan_unit(SHIFT);
          end else begin
            x_d[l]   = x_q[k-1][l] - (y_q[k-1][l] >>> SHIFT);
            y_d[l]   = y_q[k-1][l] + (x_q[k-1][l] >>> SHIFT);
            ang_d[l] = ang_q[k-1][l] - stcg_pkg::atan_unit(SHIFT);
          end
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[k] <= 1'b0;
        end else begin
          valid_q[k] <= valid_q[k-1];
        end
      end

      always_ff @(posedge clk_i) begin
        flags_q[k] <= flags_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < L; l++) begin
        x_q[k][l]   <= x_d[l];
        y_q[k][l]   <= y_d[l];
        ang_q[k][l] <= ang_d[l];
      end
    end
  end

  assign valid_o = valid_q[STAGES];
  assign flags_o = flags_q[STAGES];

  for (genvar l = 0; l < L; l++) begin : g_out
    assign ang_o[l] = ang_q[STAGES][l];
  end

endmodule

@@ rtl/stcg_back.sv @@
// Back end: special cases, format conversion of both angles and the result register.
module stcg_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  stcg_pkg::flags_t  flags_i,
  input  stcg_pkg::ang_t    ang_u_i,
  input  stcg_pkg::ang_t    ang_v_i,
  output logic              done_o,
  output stcg_pkg::tex_t    res_o
);

  localparam int TW = stcg_pkg::TEX_W;
  localparam int AW = stcg_pkg::ANG_W;
  localparam int UW = stcg_pkg::TURN_W;

  logic           done_q;
  stcg_pkg::tex_t res_q;
  stcg_pkg::tex_t res_d;

  always_comb begin
    if (flags_i.z_zero) begin
      res_d.tex_u = flags_i.x_neg ? stcg_pkg::U_HALF : stcg_pkg::U_ZERO;
    end else if (flags_i.x_zero) begin
      res_d.tex_u = flags_i.z_pos ? stcg_pkg::U_QUARTER_POS : stcg_pkg::U_QUARTER_NEG;
    end else begin
      res_d.tex_u = ang_u_i[UW-1 -: TW];
    end

    // The polar angle is clamped to half a turn and saturates at the top code.
    if (flags_i.xz_zero) begin
      res_d.tex_v = flags_i.y_pos ? stcg_pkg::V_ZERO : stcg_pkg::V_MAX;
    end else if (flags_i.y_zero) begin
      res_d.tex_v = stcg_pkg::V_HALF;
    end else if (ang_v_i[AW-1]) begin
      res_d.tex_v = stcg_pkg::V_ZERO;
    end else if (|ang_v_i[AW-2:UW-1]) begin
      res_d.tex_v = stcg_pkg::V_MAX;
    end else begin
      res_d.tex_v = ang_v_i[UW-2 -: TW];
    end

    res_d.zero_vector = flags_i.zero_vector;
    if (flags_i.zero_vector) begin
      res_d.tex_u = stcg_pkg::U_ZERO;
      res_d.tex_v = stcg_pkg::V_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/spherical_texcoord_gen_top.sv @@
// Top level of the spherical texture coordinate generator.
//
// The block turns one vertex position (signed Q8.8 x, y, z) into spherical
// texture coordinates: tex_u is the azimuth atan2(z, x) as a signed fraction
// of a turn, tex_v is the polar angle as an unsigned fraction of half a turn,
// and zero_vector marks the origin, for which both coordinates are zero.
// An item is taken on pos_i at a rising edge where start_i is high and busy_o
// is low. busy_o is high only while reset is applied and in the first cycle
// after it; from then on an item may be started in every cycle.
// The result appears on res_o with done_o high for exactly one cycle,
// after the item has passed through three front stages (input, squares,
// sum), sixteen square-root stages, one half-plane stage plus CORDIC_STAGES
// rotation stages, and the result register. Throughput is one item per
// cycle, set by the fully pipelined square root and the two-lane CORDIC,
// which resolves both angles side by side.
// The receiver cannot hold results off, and the pipeline never stalls.
// Reset clears every valid bit, so items in flight are dropped and no result
// is given for them; payload registers are not reset.
module spherical_texcoord_gen_top #(
  parameter int CORDIC_STAGES = stcg_pkg::CORDIC_STAGES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  stcg_pkg::pos_t  pos_i,
  output logic            done_o,
  output stcg_pkg::tex_t  res_o
);

  localparam int GW = stcg_pkg::GUARD_W;

  logic                            busy_q;
  logic                            accept;

  logic                            front_valid;
  stcg_pkg::sq_side_t              front_side;
  logic [stcg_pkg::SQ_W-1:0]       front_sum;

  logic                            sqrt_valid;
  stcg_pkg::sq_side_t              sqrt_side;
  logic [stcg_pkg::COORD_W-1:0]    sqrt_root;

  stcg_pkg::cval_t                 vec_x [stcg_pkg::LANES];
  stcg_pkg::cval_t                 vec_y [stcg_pkg::LANES];

  logic                            cordic_valid;
  stcg_pkg::flags_t                cordic_flags;
  stcg_pkg::ang_t                  cordic_ang [stcg_pkg::LANES];

  // The block refuses items only while it comes out of reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  stcg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pos_i   (pos_i),
    .valid_o (front_valid),
    .side_o  (front_side),
    .sum_o   (front_sum)
  );

  // The radius in the x-z plane is the floor square root of x squared plus z squared.
  stcg_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .side_i  (front_side),
    .rad_i   (front_sum),
    .valid_o (sqrt_valid),
    .side_o  (sqrt_side),
    .root_o  (sqrt_root)
  );

  // Both operands of each angle get the same number of guard bits so that
  // the CORDIC keeps its precision; the azimuth lane measures (x, z) and the
  // polar lane measures (y, radius).
  always_comb begin
    vec_x[stcg_pkg::LANE_U] = stcg_pkg::cval_t'(sqrt_side.pos.pos_x) <<< GW;
    vec_y[stcg_pkg::LANE_U] = stcg_pkg::cval_t'(sqrt_side.pos.pos_z) <<< GW;
    vec_x[stcg_pkg::LANE_V] = stcg_pkg::cval_t'(sqrt_side.pos.pos_y) <<< GW;
    vec_y[stcg_pkg::LANE_V] = stcg_pkg::cval_t'(sqrt_root) << GW;
  end

  stcg_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sqrt_valid),
    .flags_i (sqrt_side.flags),
    .vec_x_i (vec_x),
    .vec_y_i (vec_y),
    .valid_o (cordic_valid),
    .flags_o (cordic_flags),
    .ang_o   (cordic_ang)
  );

  // Axis cases bypass the angles, and the result is registered once more.
  stcg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cordic_valid),
    .flags_i (cordic_flags),
    .ang_u_i (cordic_ang[stcg_pkg::LANE_U]),
    .ang_v_i (cordic_ang[stcg_pkg::LANE_V]),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule

@@ rtl/stcg_checker.sv @@
// Port-level checks of the texture coordinate generator and their binding to the top level.
module stcg_checker #(
  parameter int CORDIC_STAGES = stcg_pkg::CORDIC_STAGES_DEF
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input stcg_pkg::pos_t  pos_i,
  input logic            done_o,
  input stcg_pkg::tex_t  res_o
);

  localparam int LAT = stcg_pkg::FRONT_STAGES + stcg_pkg::SQRT_STAGES + CORDIC_STAGES + 2;

  // Every result belongs to an item that the block took before it.
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without a matching item");

  // No item is lost in the pipeline.
  a_item_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("item taken but no result given");

  // The origin flag follows the position that was taken.
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.zero_vector ==
                $past(pos_i.pos_x == '0 && pos_i.pos_y == '0 && pos_i.pos_z == '0, LAT)))
    else $error("zero_vector does not match the position");

  // The origin gives zero coordinates.
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.zero_vector) |-> (res_o.tex_u == '0 && res_o.tex_v == '0))
    else $error("origin with nonzero coordinates");

endmodule

bind spherical_texcoord_gen_top stcg_checker #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_stcg_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .pos_i   (pos_i),
  .done_o  (done_o),
  .res_o   (res_o)
);

@@ tb/spherical_texcoord_gen_top_tb.sv @@
// Self-checking testbench for the spherical texture coordinate generator.
`timescale 1ns / 1ps

module spherical_texcoord_gen_top_tb;
  import stcg_pkg::*;

  // Rotation stages of the device under test, and its latency in cycles from
  // the accepting edge to the result strobe.
  localparam int NUM_ROT  = CORDIC_STAGES_DEF;
  localparam int LATENCY  = 21 + NUM_ROT;
  localparam longint HALF = 64'sd2147483648;

  // Scoreboard: predicts each vertex's texture coordinates when the vertex is
  // accepted and checks them, in order, against the results that come back.
  class texcoord_scoreboard;
    tex_t   pending_tex[$];
    int     fail_count;
    longint atan_turn[32];

    function new();
      fail_count = 0;
      // Arctangent of 2^-i in binary angle units, 2^32 to the turn.
      atan_turn = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
        64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051,
        64'h00000028, 64'h00000014, 64'h0000000A, 64'h00000005,
        64'h00000002, 64'h00000001, 64'h00000000, 64'h00000000};
    endfunction

    // Exact integer floor square root.
    function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root, probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
        if (n >= root + probe) begin
          n    = n - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root;
    endfunction

    // Binary angle of the vector (ax, ay) by vectoring rotations; the left
    // half-plane is folded over first, starting from plus or minus half a turn.
    function automatic longint vector_angle(longint ax, longint ay);
      longint cx, cy, acc, dx, dy;
      cx  = ax;
      cy  = ay;
      acc = 0;
      if (ax < 0) begin
        cx  = -ax;
        cy  = -ay;
        acc = (ay >= 0) ? HALF : -HALF;
      end
      for (int i = 0; i < NUM_ROT && i < 32; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx  = cx + dx;
          cy  = cy - dy;
          acc = acc + atan_turn[i];
        end else begin
          cx  = cx - dx;
          cy  = cy + dy;
          acc = acc - atan_turn[i];
        end
      end
      return acc;
    endfunction

    function automatic tex_t predict_texcoord(pos_t p);
      tex_t            t;
      longint          px, py, pz, scale, ang;
      longint unsigned radius, vq;
      px    = longint'(p.pos_x);
      py    = longint'(p.pos_y);
      pz    = longint'(p.pos_z);
      scale = 64'sd1 <<< GUARD_W;
      t     = '0;
      if (px == 0 && py == 0 && pz == 0) begin
        t.zero_vector = 1'b1;
        return t;
      end
      // Azimuth: the axes give exact codes, everything else goes round.
      if (pz == 0)
        t.tex_u = (px >= 0) ? U_ZERO : U_HALF;
      else if (px == 0)
        t.tex_u = (pz > 0) ? U_QUARTER_POS : U_QUARTER_NEG;
      else begin
        ang     = vector_angle(px * scale, pz * scale);
        t.tex_u = ang[31:16];
      end
      // Polar angle from y and the radius in the x-z plane.
      radius = floor_sqrt(longint'(px * px + pz * pz));
      if (radius == 0)
        t.tex_v = (py > 0) ? V_ZERO : V_MAX;
      else if (py == 0)
        t.tex_v = V_HALF;
      else begin
        ang = vector_angle(py * scale, longint'(radius) * scale);
        if (ang < 0) ang = 0;
        if (ang > HALF) ang = HALF;
        vq = longint'(ang) >> 15;
        if (vq > 65535) vq = 65535;
        t.tex_v = vq[15:0];
      end
      return t;
    endfunction

    function void note_vertex(pos_t p);
      pending_tex.push_back(predict_texcoord(p));
    endfunction

    function void check_texcoord(tex_t got);
      tex_t want;
      if (pending_tex.size() == 0) begin
        $error("result with no item outstanding: u=%0d v=%0d zero=%0b",
               got.tex_u, got.tex_v, got.zero_vector);
        fail_count++;
        return;
      end
      want = pending_tex.pop_front();
      if (got.tex_u !== want.tex_u) begin
        $error("tex_u mismatch: expected %0d, got %0d", want.tex_u, got.tex_u);
        fail_count++;
      end
      if (got.tex_v !== want.tex_v) begin
        $error("tex_v mismatch: expected %0d, got %0d", want.tex_v, got.tex_v);
        fail_count++;
      end
      if (got.zero_vector !== want.zero_vector) begin
        $error("zero_vector mismatch: expected %0b, got %0b",
               want.zero_vector, got.zero_vector);
        fail_count++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  pos_t pos_i;
  logic done_o;
  tex_t res_o;

  texcoord_scoreboard sb = new();

  spherical_texcoord_gen_top #(
    .CORDIC_STAGES(NUM_ROT)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .pos_i  (pos_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog, with a very wide margin over the slowest correct run.
  initial begin
    #1ms;
    $display("simulation failed");
    $finish;
  end

  // Monitor. All inputs are driven with nonblocking assignments and the
  // outputs of the block change the same way, so the values seen here at the
  // rising edge are the ones that held in the cycle that edge closes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_vertex(pos_i);
      if (done_o) sb.check_texcoord(res_o);
    end
  end

  function automatic pos_t make_pos(int x, int y, int z);
    pos_t p;
    p.pos_x = x[15:0];
    p.pos_y = y[15:0];
    p.pos_z = z[15:0];
    return p;
  endfunction

  // One random coordinate. Zeros and small values are weighted up so that the
  // axis and near-axis cases turn up often; the rest spans the whole range.
  function automatic logic [15:0] rand_coord();
    logic [15:0] c;
    case ($urandom_range(7))
      0:       c = '0;
      1:       c = 16'($signed($urandom_range(16)) - 8);
      2:       c = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
      default: c = 16'($urandom);
    endcase
    return c;
  endfunction

  // Presents one item and holds it until it is taken. After that, each cycle
  // is an idle one with the given chance in a hundred, with start low and
  // noise on the position bus; otherwise the next item follows at once.
  task automatic send_vertex(pos_t p, int idle_pct);
    start_i <= 1'b1;
    pos_i   <= p;
    do @(posedge clk_i); while (busy_o);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      pos_i   <= pos_t'({$urandom, $urandom});
      @(posedge clk_i);
    end
  endtask

  task automatic run_random(int count, int idle_pct);
    pos_t p;
    for (int n = 0; n < count; n++) begin
      p.pos_x = rand_coord();
      p.pos_y = rand_coord();
      p.pos_z = rand_coord();
      send_vertex(p, idle_pct);
    end
  endtask

  initial begin
    int drain_cycles;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    pos_i   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items: the origin, both ends of every axis, the azimuth wrap at
    // half a turn, the equator, and the corners of the coordinate range.
    send_vertex(make_pos(0, 0, 0), 13);
    send_vertex(make_pos(0, 1, 0), 13);
    send_vertex(make_pos(0, -1, 0), 13);
    send_vertex(make_pos(0, 32767, 0), 13);
    send_vertex(make_pos(0, -32768, 0), 13);
    send_vertex(make_pos(1, 0, 0), 13);
    send_vertex(make_pos(32767, 5, 0), 13);
    send_vertex(make_pos(-1, 3, 0), 13);
    send_vertex(make_pos(-32768, -9, 0), 13);
    send_vertex(make_pos(0, -7, 32767), 13);
    send_vertex(make_pos(0, 9, -32768), 13);
    send_vertex(make_pos(0, 0, 1), 13);
    send_vertex(make_pos(100, 0, -200), 13);
    send_vertex(make_pos(32767, 32767, 32767), 13);
    send_vertex(make_pos(-32768, -32768, -32768), 13);
    send_vertex(make_pos(-32768, 32767, -32768), 13);
    send_vertex(make_pos(32767, -32768, 1), 13);
    send_vertex(make_pos(-32768, 1, 32767), 13);
    send_vertex(make_pos(1, 1, 1), 13);
    send_vertex(make_pos(-1, -1, -1), 13);
    send_vertex(make_pos(-1, 2, -1), 13);
    send_vertex(make_pos(0, 0, -1), 13);
    send_vertex(make_pos(1, -32768, 0), 13);

    // Random items: the sender idles rarely, then mostly, then never.
    run_random(200, 13);
    run_random(200, 85);
    run_random(200, 0);
    start_i <= 1'b0;

    // Let the pipeline empty, then watch a while longer for stray results.
    drain_cycles = 0;
    while (sb.pending_tex.size() != 0 && drain_cycles < 20 * LATENCY) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (2 * LATENCY) @(posedge clk_i);

    if (sb.fail_count == 0 && sb.pending_tex.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (sb.pending_tex.size() != 0)
        $error("%0d results never arrived", sb.pending_tex.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
